@@ hdl/button_report_change_events_defines.svh @@
// Assertion macros shared by the button report change detector.
`ifndef BUTTON_REPORT_CHANGE_EVENTS_DEFINES_SVH
`define BUTTON_REPORT_CHANGE_EVENTS_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define BRCE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("brce assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define BRCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("brce assertion failed");

`endif

@@ hdl/brce_pkg.sv @@
// Shared types and constants of the button report change detector.
package brce_pkg;

  localparam int unsigned BUTTON_BYTES_DEF  = 6;
  localparam int unsigned MAX_BUTTONS       = 48;
  localparam int unsigned MAX_BUTTON_EVENTS = 28;
  localparam int unsigned CNT_W             = 5;
  localparam int unsigned IDX_W             = 6;
  localparam int unsigned APB_AW            = 4;
  localparam int unsigned APB_DW            = 64;

  localparam logic [7:0]             REPORT_ID_BUTTONS = 8'h01;
  localparam logic [7:0]             ENC_TOP           = 8'h0f;
  localparam logic [7:0]             ENC_BOTTOM        = 8'h00;
  localparam logic                   KIND_BUTTON       = 1'b0;
  localparam logic                   KIND_ENCODER      = 1'b1;
  localparam logic                   REG_EVENT_MASK    = 1'b0;
  localparam logic [MAX_BUTTONS-1:0] MASK_RESET        = 48'h0000_FFFF_F8FE;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic enc;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic id_ok;
    logic scan_last;
    logic stall;
    logic pend_valid;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic             event_kind;
    logic [IDX_W-1:0] button_index;
    logic             pressed_now;
    logic             moved_up;
    logic             shift_held;
    logic             last_event;
  } event_t;

endpackage

@@ hdl/brce_if.sv @@
// Valid/ready channel interfaces for input reports and output events.
interface brce_report_if;
  logic        valid;
  logic        ready;
  logic [7:0]  report_id;
  logic [47:0] button_bits;
  logic [7:0]  encoder_value;

  modport source (output valid, output report_id, output button_bits,
                  output encoder_value, input ready);
  modport sink (input valid, input report_id, input button_bits,
                input encoder_value, output ready);
endinterface

interface brce_event_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [5:0] button_index;
  logic       pressed_now;
  logic       moved_up;
  logic       shift_held;
  logic       last_event;

  modport source (output valid, output event_kind, output button_index,
                  output pressed_now, output moved_up, output shift_held,
                  output last_event, input ready);
  modport sink (input valid, input event_kind, input button_index,
                input pressed_now, input moved_up, input shift_held,
                input last_event, output ready);
endinterface

@@ hdl/brce_ctrl.sv @@
// Controller state machine that sequences the scan of one report.
module brce_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  brce_pkg::sts_t  sts_i,
  output brce_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_ENC   = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        // Reports with another id are taken and dropped here.
        cmd_o.load = in_valid_i && sts_i.id_ok;
        if (cmd_o.load) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (!sts_i.stall && sts_i.scan_last) begin
          state_d = ST_ENC;
        end
      end
      ST_ENC: begin
        cmd_o.enc = 1'b1;
        if (!sts_i.stall) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (!sts_i.pend_valid || sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/brce_datapath.sv @@
// Datapath: captured report, stored states, bit scan, pending event and output register.
`include "button_report_change_events_defines.svh"

module brce_datapath #(
  parameter int unsigned BUTTON_BYTES = brce_pkg::BUTTON_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  brce_pkg::cmd_t                   cmd_i,
  output brce_pkg::sts_t                   sts_o,
  input  logic [7:0]                       report_id_i,
  input  logic [brce_pkg::MAX_BUTTONS-1:0] button_bits_i,
  input  logic [7:0]                       encoder_value_i,
  input  logic [brce_pkg::MAX_BUTTONS-1:0] mask_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output brce_pkg::event_t                 out_event_o
);

  localparam int unsigned NBITS = (8 * BUTTON_BYTES > brce_pkg::MAX_BUTTONS) ?
                                  brce_pkg::MAX_BUTTONS : 8 * BUTTON_BYTES;
  localparam logic [brce_pkg::IDX_W-1:0] IDX_LAST = brce_pkg::IDX_W'(NBITS - 1);
  localparam logic [brce_pkg::CNT_W-1:0] CNT_MAX  =
    brce_pkg::CNT_W'(brce_pkg::MAX_BUTTON_EVENTS);

  logic [brce_pkg::MAX_BUTTONS-1:0] bits_q, stored_q, stored_d;
  logic                             shift_q;
  logic [7:0]                       enc_q, stored_enc_q;
  logic [brce_pkg::IDX_W-1:0]       idx_q;
  logic [brce_pkg::CNT_W-1:0]       cnt_q;
  logic                             pend_valid_q;
  brce_pkg::event_t                 pend_q, new_event, move_event;
  logic                             out_valid_q;
  brce_pkg::event_t                 out_q;

  logic now_bit, was_bit, changed, enabled, enc_changed, moved_up;
  logic gen_btn, gen_enc, gen, out_free, stall, move_mid, move_last, move;

  assign now_bit     = bits_q[idx_q];
  assign was_bit     = stored_q[idx_q];
  assign changed     = now_bit != was_bit;
  assign enabled     = mask_i[idx_q] && (cnt_q < CNT_MAX);
  assign enc_changed = enc_q != stored_enc_q;

  // Wrap from 0x0f to 0x00 counts as a step up, the reverse as a step down.
  assign moved_up = ((stored_enc_q < enc_q) ||
                     (stored_enc_q == brce_pkg::ENC_TOP && enc_q == brce_pkg::ENC_BOTTOM)) &&
                    !(stored_enc_q == brce_pkg::ENC_BOTTOM && enc_q == brce_pkg::ENC_TOP);

  assign gen_btn   = cmd_i.scan && changed && enabled;
  assign gen_enc   = cmd_i.enc && enc_changed;
  assign gen       = gen_btn || gen_enc;
  assign out_free  = !out_valid_q || out_ready_i;
  // A new event needs the pending slot, whose item must first move out.
  assign stall     = gen && pend_valid_q && !out_free;
  assign move_mid  = gen && pend_valid_q && out_free;
  assign move_last = cmd_i.flush && pend_valid_q && out_free;
  assign move      = move_mid || move_last;

  always_comb begin
    new_event            = '0;
    new_event.shift_held = shift_q;
    if (cmd_i.enc) begin
      new_event.event_kind = brce_pkg::KIND_ENCODER;
      new_event.moved_up   = moved_up;
    end else begin
      new_event.event_kind   = brce_pkg::KIND_BUTTON;
      new_event.button_index = idx_q;
      new_event.pressed_now  = now_bit;
    end
  end

  // The item leaving the pending slot is the final one of its report on a flush.
  always_comb begin
    move_event            = pend_q;
    move_event.last_event = move_last;
  end

  always_comb begin
    stored_d = stored_q;
    if (cmd_i.scan && !stall && changed) begin
      stored_d[idx_q] = now_bit;
    end
  end

  assign sts_o.id_ok      = (report_id_i == brce_pkg::REPORT_ID_BUTTONS);
  assign sts_o.scan_last  = (idx_q == IDX_LAST);
  assign sts_o.stall      = stall;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;

  // Captured report and event payloads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bits_q  <= button_bits_i;
      shift_q <= button_bits_i[0];
      enc_q   <= encoder_value_i;
    end
    if (gen && !stall) begin
      pend_q <= new_event;
    end
    if (move) begin
      out_q <= move_event;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q     <= '0;
      stored_enc_q <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      stored_q <= stored_d;
      if (cmd_i.load) begin
        idx_q <= brce_pkg::IDX_W'(1);
        cnt_q <= '0;
      end else if (cmd_i.scan && !stall && !sts_o.scan_last) begin
        idx_q <= idx_q + brce_pkg::IDX_W'(1);
      end
      if (gen_btn && !stall) begin
        cnt_q <= cnt_q + brce_pkg::CNT_W'(1);
      end
      if (cmd_i.enc && !stall) begin
        stored_enc_q <= enc_q;
      end
      if (gen && !stall) begin
        pend_valid_q <= 1'b1;
      end else if (move_last) begin
        pend_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_event_o = out_q;

  `BRCE_ASSERT_NOW(a_cnt_max, 1'b1, cnt_q <= CNT_MAX)
  `BRCE_ASSERT_NOW(a_shift_unstored, 1'b1, stored_q[0] == 1'b0)
  `BRCE_ASSERT_NOW(a_load_empty, cmd_i.load, !pend_valid_q)
  `BRCE_ASSERT_NEXT(a_flush_marks_last, move_last, out_valid_q && out_q.last_event)

endmodule

@@ hdl/button_report_change_events.sv @@
// Top level of the button report change detector: channels, mask register, controller, datapath.
//
//   channel    dir  handshake          carries
//   report_i   in   valid/ready        report_id, button_bits, encoder_value
//   event_o    out  valid/ready        event_kind .. last_event
//   APB        in   psel/penable       event_enable_mask at byte address 0
//
// A report with id 1 passes through the accept step, the scan of one button bit a cycle
// when no stall holds it (bit 1 to the top bit), the encoder step and the hand-out of
// the final event. Reports with another id are taken and dropped.
// The scan and the encoder step stall when an event is found while the pending slot is
// full and the output register is full and not being read; the final hand-out waits for
// the output register. Reset clears stored states and sets the mask to its default.
module button_report_change_events #(
  parameter int unsigned BUTTON_BYTES = brce_pkg::BUTTON_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  brce_report_if.sink                  report_i,
  brce_event_if.source                 event_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [brce_pkg::APB_AW-1:0]  paddr,
  input  logic [brce_pkg::APB_DW-1:0]  pwdata,
  output logic [brce_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  logic [brce_pkg::MAX_BUTTONS-1:0] mask_q;
  logic                             reg_sel;
  brce_pkg::cmd_t                   cmd;
  brce_pkg::sts_t                   sts;
  brce_pkg::event_t                 ev;
  logic                             in_ready;

  assign reg_sel = (paddr[3] == brce_pkg::REG_EVENT_MASK);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? brce_pkg::APB_DW'(mask_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= brce_pkg::MASK_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      mask_q <= pwdata[brce_pkg::MAX_BUTTONS-1:0];
    end
  end

  brce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (report_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  brce_datapath #(
    .BUTTON_BYTES (BUTTON_BYTES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .report_id_i     (report_i.report_id),
    .button_bits_i   (report_i.button_bits),
    .encoder_value_i (report_i.encoder_value),
    .mask_i          (mask_q),
    .out_ready_i     (event_o.ready),
    .out_valid_o     (event_o.valid),
    .out_event_o     (ev)
  );

  assign report_i.ready       = in_ready;
  assign event_o.event_kind   = ev.event_kind;
  assign event_o.button_index = ev.button_index;
  assign event_o.pressed_now  = ev.pressed_now;
  assign event_o.moved_up     = ev.moved_up;
  assign event_o.shift_held   = ev.shift_held;
  assign event_o.last_event   = ev.last_event;

endmodule
